>>> rtl/art_pkg.sv
// Package: shared types and constants for the address range table.
`timescale 1ns / 1ps
package art_pkg;

   localparam int TABLE_DEPTH   = 64;
   localparam int ADDR_W        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
   localparam int ENTRY_COUNT_W = 7;
   localparam int ENTRY_W       = 64;

   localparam logic CMD_CHECK  = 1'b0;
   localparam logic CMD_INSERT = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_MISS  = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_ORDER = 2'd3
   } status_type;

   typedef struct packed {
      logic        command;
      logic [31:0] low_address;
      logic [31:0] high_address;
   } req_item_type;

   typedef struct packed {
      status_type                 status;
      logic [ENTRY_COUNT_W-1:0]   entry_count;
   } rsp_item_type;

   typedef enum logic [2:0] {
      FSM_IDLE = 3'b001,
      FSM_SCAN = 3'b010,
      FSM_DONE = 3'b100
   } fsm_type;

endpackage

>>> rtl/address_range_table_core.sv
// Top level: address range table with insert and membership check over one RAM.
//
//   channel   ports                          handshake
//   request   start, busy, req_item          taken when start && !busy
//   response  rsp_valid, rsp_item            one-cycle strobe, no backpressure
//
// While busy, the block reads every stored entry from the RAM in turn, waits for
// the last read data, sees the scan end and then decides and writes back; an
// empty table gives no reads and an insert with start above end skips the scan.
// The result strobe follows in the cycle after the decision, with busy already
// low. The single RAM read port sets the rate. Reset clears only the count and
// the control state; RAM contents stay undefined and only written entries are
// read. The receiver cannot stall.
`timescale 1ns / 1ps
module address_range_table_core
   import art_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_valid,
   output rsp_item_type rsp_item
);

   fsm_type              state_ff,   state_in;
   req_item_type         item_ff,    item_in;
   logic [CNT_W-1:0]     count_ff,   count_in;
   logic [CNT_W-1:0]     issue_ff,   issue_in;
   logic                 pend_ff,    pend_in;
   logic                 hit_ff,     hit_in;
   logic                 order_ff,   order_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_item_type         rsp_item_ff,  rsp_item_in;

   logic                 accept;
   logic                 rd_en;
   logic                 wr_en;
   logic [ENTRY_W-1:0]   rd_data;
   logic [31:0]          ent_start;
   logic [31:0]          ent_end;
   logic                 ent_hit;
   status_type           status;

   assign accept    = start && !busy;
   assign busy      = (state_ff != FSM_IDLE);
   assign ent_start = rd_data[ENTRY_W-1:32];
   assign ent_end   = rd_data[31:0];
   assign rd_en     = (state_ff == FSM_SCAN) && (issue_ff != count_ff);

   always_comb begin
      if (item_ff.command == CMD_INSERT) begin
         ent_hit = (item_ff.low_address <= ent_end) && (item_ff.high_address >= ent_start);
      end else begin
         ent_hit = (item_ff.low_address >= ent_start) && (item_ff.low_address <= ent_end);
      end
   end

   always_comb begin
      wr_en = 1'b0;
      if (order_ff) begin
         status = STATUS_ORDER;
      end else if (item_ff.command == CMD_CHECK) begin
         status = hit_ff ? STATUS_OK : STATUS_MISS;
      end else if (hit_ff) begin
         status = STATUS_MISS;
      end else if (count_ff >= CNT_W'(TABLE_DEPTH)) begin
         status = STATUS_FULL;
      end else begin
         status = STATUS_OK;
         wr_en  = (state_ff == FSM_DONE);
      end
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      pend_in      = 1'b0;
      hit_in       = hit_ff;
      order_in     = order_ff;
      rsp_valid_in = 1'b0;
      rsp_item_in  = rsp_item_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               item_in  = req_item;
               issue_in = '0;
               hit_in   = 1'b0;
               order_in = (req_item.command == CMD_INSERT) &&
                          (req_item.low_address > req_item.high_address);
               state_in = order_in ? FSM_DONE : FSM_SCAN;
            end
         end
         FSM_SCAN: begin
            if (rd_en) begin
               issue_in = issue_ff + CNT_W'(1);
               pend_in  = 1'b1;
            end
            if (pend_ff && ent_hit) begin
               hit_in = 1'b1;
            end
            if (!rd_en && !pend_ff) begin
               state_in = FSM_DONE;
            end
         end
         FSM_DONE: begin
            if (wr_en) begin
               count_in = count_ff + CNT_W'(1);
            end
            rsp_valid_in            = 1'b1;
            rsp_item_in.status      = status;
            rsp_item_in.entry_count = ENTRY_COUNT_W'(count_in);
            state_in                = FSM_IDLE;
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      issue_ff    <= issue_in;
      hit_ff      <= hit_in;
      order_ff    <= order_in;
      rsp_item_ff <= rsp_item_in;
   end

   art_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ranges (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data ({item_ff.low_address, item_ff.high_address}),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count above table depth");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("not busy after accepting an item");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response strobe while busy");

   a_pend_scan: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == FSM_SCAN))
      else $error("read data pending outside scan");

   a_write_room: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (count_ff < CNT_W'(TABLE_DEPTH)) && !pend_ff)
      else $error("write into a full table or during a scan");
`endif

endmodule

>>> rtl/art_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module art_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> tb/range_table_checker.sv
// Checker: predicts address range table results and compares them with the block's output.
`timescale 1ns / 1ps
module range_table_checker
   import art_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         busy,
   input  req_item_type req_item,
   input  logic         rsp_valid,
   input  rsp_item_type rsp_item,
   output int           error_count,
   output int           pending_count
);

   logic [31:0]  range_lo_model [TABLE_DEPTH];
   logic [31:0]  range_hi_model [TABLE_DEPTH];
   int unsigned  ranges_stored;
   rsp_item_type expected_rsps [$];

   task automatic flag_error(input string msg);
      $display("%0t ns: ERROR %s", $time, msg);
      error_count = error_count + 1;
   endtask

   function automatic rsp_item_type predict_range_item(input req_item_type it);
      rsp_item_type r;
      logic         hit;
      hit = 1'b0;
      if (it.command == CMD_CHECK) begin
         for (int i = 0; i < ranges_stored; i++)
            if (it.low_address >= range_lo_model[i] && it.low_address <= range_hi_model[i])
               hit = 1'b1;
         r.status = hit ? STATUS_OK : STATUS_MISS;
      end else if (it.low_address > it.high_address) begin
         r.status = STATUS_ORDER;
      end else begin
         for (int i = 0; i < ranges_stored; i++)
            if (it.low_address <= range_hi_model[i] && it.high_address >= range_lo_model[i])
               hit = 1'b1;
         if (hit) begin
            r.status = STATUS_MISS;
         end else if (ranges_stored >= TABLE_DEPTH) begin
            r.status = STATUS_FULL;
         end else begin
            range_lo_model[ranges_stored] = it.low_address;
            range_hi_model[ranges_stored] = it.high_address;
            ranges_stored = ranges_stored + 1;
            r.status = STATUS_OK;
         end
      end
      r.entry_count = ENTRY_COUNT_W'(ranges_stored);
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         ranges_stored = 0;
         expected_rsps.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_rsps.size() == 0) begin
               flag_error($sformatf("result with no item pending: status %0d count %0d",
                                    rsp_item.status, rsp_item.entry_count));
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_item.status !== want.status)
                  flag_error($sformatf("status %0d, expected %0d",
                                       rsp_item.status, want.status));
               if (rsp_item.entry_count !== want.entry_count)
                  flag_error($sformatf("entry_count %0d, expected %0d",
                                       rsp_item.entry_count, want.entry_count));
            end
         end
         if (start && !busy)
            expected_rsps.push_back(predict_range_item(req_item));
      end
      pending_count = expected_rsps.size();
   end

endmodule

>>> tb/testbench.sv
// Testbench top: drives address range table items, watches for hangs and gives the verdict.
`timescale 1ns / 1ps
module testbench;
   import art_pkg::*;

   localparam int PHASE_ITEMS  = 360;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = TABLE_DEPTH + 16;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_item_type req_item;
   logic         rsp_valid;
   rsp_item_type rsp_item;

   int          error_count;
   int          pending_count;
   int          quiet_cycles;
   int          idle_pct;
   logic [31:0] sent_lo [$];
   logic [31:0] sent_hi [$];

   address_range_table_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   range_table_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_item      (req_item),
      .rsp_valid     (rsp_valid),
      .rsp_item      (rsp_item),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_valid)
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Regression FAIL");
      $finish;
   end

   function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] k);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, k};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic logic [31:0] sub_sat(input logic [31:0] a, input logic [31:0] k);
      return (a < k) ? 32'h0 : a - k;
   endfunction

   // called at a falling edge; returns at the falling edge after the item is taken
   task automatic send_item(input logic cmd, input logic [31:0] lo, input logic [31:0] hi);
      req_item_type it;
      it.command      = cmd;
      it.low_address  = lo;
      it.high_address = hi;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start    <= 1'b1;
      req_item <= it;
      while (busy) @(negedge clock);
      @(negedge clock);
      if (cmd == CMD_INSERT && lo <= hi) begin
         sent_lo.push_back(lo);
         sent_hi.push_back(hi);
      end
   endtask

   task automatic random_item();
      int          roll;
      int          pick;
      logic [31:0] k;
      logic [31:0] lo;
      logic [31:0] hi;
      logic [31:0] base_lo;
      logic [31:0] base_hi;
      roll = $urandom_range(99);
      k    = $urandom_range(0, 1 << $urandom_range(0, 12));
      pick = 0;
      base_lo = 32'h0;
      base_hi = 32'h0;
      if (sent_lo.size() > 0) begin
         pick    = $urandom_range(sent_lo.size() - 1);
         base_lo = sent_lo[pick];
         base_hi = sent_hi[pick];
      end
      if (roll < 45) begin
         if (sent_lo.size() == 0 || $urandom_range(3) == 0) begin
            lo = $urandom();
         end else begin
            case ($urandom_range(4))
               0: lo = base_lo;
               1: lo = base_hi;
               2: lo = sub_sat(base_lo, 1);
               3: lo = add_sat(base_hi, 1);
               default: begin
                  lo = add_sat(base_lo, k);
                  if (lo > base_hi) lo = base_hi;
               end
            endcase
         end
         send_item(CMD_CHECK, lo, $urandom());
      end else if (roll < 75 && sent_lo.size() > 0) begin
         case ($urandom_range(5))
            0: begin
               lo = sub_sat(base_lo, k);
               hi = base_lo;
            end
            1: begin
               lo = base_hi;
               hi = add_sat(base_hi, k);
            end
            2: begin
               lo = add_sat(base_lo, k);
               if (lo > base_hi) lo = base_hi;
               hi = lo;
            end
            3: begin
               lo = sub_sat(base_lo, k);
               hi = add_sat(base_hi, k);
            end
            4: begin
               hi = sub_sat(base_lo, 1);
               lo = sub_sat(hi, k);
            end
            default: begin
               lo = add_sat(base_hi, 1);
               hi = add_sat(lo, k);
            end
         endcase
         send_item(CMD_INSERT, lo, hi);
      end else if (roll < 81) begin
         lo = $urandom();
         send_item(CMD_INSERT, lo, add_sat(lo, k));
      end else if (roll < 93) begin
         lo = $urandom() | 32'h1;
         send_item(CMD_INSERT, lo, sub_sat(lo, k + 1));
      end else begin
         send_item(CMD_INSERT, $urandom(), $urandom());
      end
   endtask

   initial begin
      reset    = 1'b1;
      start    = 1'b0;
      req_item = '0;
      idle_pct = 13;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty table, reversed bounds, extremes, touching and enclosing ranges
      send_item(CMD_CHECK,  32'h0000_0000, 32'h0000_0000);
      send_item(CMD_CHECK,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(CMD_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
      send_item(CMD_INSERT, 32'h0000_0001, 32'h0000_0000);
      send_item(CMD_INSERT, 32'h0000_0000, 32'h0000_0000);
      send_item(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(CMD_CHECK,  32'h0000_0000, 32'hFFFF_FFFF);
      send_item(CMD_CHECK,  32'hFFFF_FFFF, 32'h0000_0000);
      send_item(CMD_CHECK,  32'h0000_0001, 32'h5555_5555);
      send_item(CMD_INSERT, 32'h0000_0000, 32'h0000_0005);
      send_item(CMD_INSERT, 32'd1000,      32'd2000);
      send_item(CMD_INSERT, 32'd500,       32'd3000);
      send_item(CMD_INSERT, 32'd1500,      32'd1600);
      send_item(CMD_INSERT, 32'd2000,      32'd2500);
      send_item(CMD_INSERT, 32'd2001,      32'd2500);
      send_item(CMD_INSERT, 32'd1,         32'd999);
      send_item(CMD_CHECK,  32'd2000,      32'hAAAA_AAAA);
      send_item(CMD_CHECK,  32'd2501,      32'h0000_0000);
      send_item(CMD_CHECK,  32'd1000,      32'hFFFF_FFFF);
      send_item(CMD_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
      send_item(CMD_INSERT, 32'hAAAA_AAAA, 32'h5555_5555);
      send_item(CMD_INSERT, 32'h5555_5555, 32'hAAAA_AAAA);
      send_item(CMD_CHECK,  32'h7FFF_FFFF, 32'h0000_0000);

      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 13 : (phase == 1) ? 59 : 0;
         repeat (PHASE_ITEMS) random_item();
      end

      start <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
